FILE: hw/rtl/bloom_filter_eight_string_hashes_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef BLOOM_FILTER_EIGHT_STRING_HASHES_UNIT_DEFINES_SVH
`define BLOOM_FILTER_EIGHT_STRING_HASHES_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/bfh_pkg.sv
// Package: constants and types for the bloom filter.
package bfh_pkg;
    localparam int unsigned FILTER_SIZE_DEF = 1048576;
    localparam logic [31:0] RS_MUL_INIT  = 32'd63689;
    localparam logic [31:0] RS_MUL_STEP  = 32'd378551;
    localparam logic [31:0] JS_INIT      = 32'd1315423911;
    localparam logic [31:0] DJB_INIT     = 32'd5381;
    localparam logic [31:0] AP_INIT      = 32'hAAAAAAAA;
    localparam logic [31:0] TOP_MASK     = 32'hF0000000;
    localparam logic [31:0] BKDR_SEED    = 32'd131;
    localparam logic        ACT_ADD      = 1'b0;
    localparam logic        ACT_TEST     = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_CLEAR,
        t_ST_MOD,
        t_ST_READ,
        t_ST_WAIT,
        t_ST_WRITE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] value;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_mod_rsp;
endpackage

FILE: hw/rtl/bfh_mod.sv
// Remainder by the filter size through reciprocal multiplication; operand, estimate and remainder are registered.
module bfh_mod import bfh_pkg::*; #(
    parameter int unsigned FILTER_SIZE = FILTER_SIZE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);
    localparam logic [31:0] DIVISOR = 32'(FILTER_SIZE);
    // floor(2^32 / divisor): the quotient estimate is low by at most one
    localparam logic [31:0] RECIP   = 32'(64'h1_0000_0000 / 64'(FILTER_SIZE));

    logic [31:0] r_x, r_q, r_r;
    logic        r_v1, r_v2;
    logic [31:0] q_est;

    assign q_est = 32'((64'(i_req.value) * 64'(RECIP)) >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
        end
        if (i_req.start) begin
            r_x <= i_req.value;
            r_q <= q_est;
        end
        if (r_v1) begin
            r_r <= r_x - r_q * DIVISOR;
        end
    end

    // Fold the one possible extra divisor out of the partial remainder.
    assign o_rsp.done = r_v2;
    assign o_rsp.rem  = (r_r >= DIVISOR) ? r_r - DIVISOR : r_r;
endmodule

FILE: hw/rtl/bloom_filter_eight_string_hashes_unit.sv
// Top level: bloom filter over byte strings with eight string hashes.
// Usage:
//   Drive one beat per byte on i_action/i_char_byte/i_end_of_string/i_no_char
//   with start high; a beat is taken when start is high and busy is low.
//   Byte beats (end_of_string low) fold into the eight hash registers;
//   busy stays low, so bytes stream at one per cycle.
//   An ending beat raises busy while each of the eight hashes is reduced
//   modulo the filter size by a reciprocal-multiply unit and its filter
//   word is read and checked or read, modified and written in the filter
//   memory (states read and wait, plus write for an add).
//   A test strobes o_member_hit via o_valid for one cycle right after busy
//   falls; an add gives no result.
//   After reset the filter memory is cleared one word per cycle, all
//   FILTER_SIZE/32 words (32768 at the default), with busy high.
//   The receiver cannot stall: each result stands exactly one cycle.
module bloom_filter_eight_string_hashes_unit import bfh_pkg::*; #(
    parameter int unsigned FILTER_SIZE = FILTER_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_action,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_string,
    input  logic       i_no_char,
    output logic       o_valid,
    output logic       o_member_hit
);
    localparam int unsigned WORDS = (FILTER_SIZE + 31) / 32;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_state r_state, n_state;
    logic [31:0] r_rs, r_rsm, r_js, r_pjw, r_elf, r_bkdr, r_djb, r_dek, r_ap, r_cnt;
    logic [31:0] n_rs, n_rsm, n_js, n_pjw, n_elf, n_bkdr, n_djb, n_dek, n_ap, n_cnt;
    logic [31:0] r_h [8];
    logic [2:0]  r_k, n_k;
    logic        r_act, r_all, n_all;
    logic [AW-1:0] r_clr, n_clr;
    logic [31:0] r_pos;
    logic [31:0] r_rd;
    logic [31:0] mem [WORDS];
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wd;
    logic        accept, finish;
    logic [31:0] c, top, pjw_t, elf_t, dek_len;
    logic [4:0]  dek_rot;
    t_mod_req    mreq;
    t_mod_rsp    mrsp;
    logic        r_valid, r_hit;
    logic        r_valid_mod;

    assign accept = start && !busy;
    assign finish = accept && i_end_of_string;
    assign c = {{24{i_char_byte[7]}}, i_char_byte};

    // Hash update for an accepted beat that carries a byte (i_no_char low).
    always_comb begin
        n_rs = r_rs; n_rsm = r_rsm; n_js = r_js; n_pjw = r_pjw; n_elf = r_elf;
        n_bkdr = r_bkdr; n_djb = r_djb; n_dek = r_dek; n_ap = r_ap; n_cnt = r_cnt;
        pjw_t = '0; elf_t = '0; top = '0;
        if (accept && !i_no_char) begin
            n_rs  = r_rs * r_rsm + c;
            n_rsm = r_rsm * RS_MUL_STEP;
            n_js  = r_js ^ ((r_js << 5) + c + (r_js >> 2));
            pjw_t = (r_pjw << 4) + c;
            n_pjw = ((pjw_t & TOP_MASK) != '0)
                  ? ((pjw_t ^ ((pjw_t & TOP_MASK) >> 24)) & ~TOP_MASK) : pjw_t;
            elf_t = (r_elf << 4) + c;
            top   = elf_t & TOP_MASK;
            n_elf = (elf_t ^ (top >> 24)) & ~top;
            n_bkdr = r_bkdr * BKDR_SEED + c;
            n_djb  = (r_djb << 5) + r_djb + c;
            n_dek  = {r_dek[26:0], r_dek[31:27]} ^ c;
            if (!r_cnt[0]) begin
                n_ap = r_ap ^ (r_ap << 7) ^ (c * (r_ap >> 3));
            end else begin
                n_ap = r_ap ^ ~((r_ap << 11) + (c ^ (r_ap >> 5)));
            end
            n_cnt = r_cnt + 32'd1;
        end
    end

    assign dek_len = n_cnt;
    assign dek_rot = 5'(dek_len * 32'd5);

    assign mreq.start = (r_state == t_ST_MOD) && (r_pos == '0) && !r_valid_mod;
    assign mreq.value = r_h[r_k];

    bfh_mod #(.FILTER_SIZE(FILTER_SIZE)) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .o_rsp  (mrsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_CLEAR: if (r_clr == AW'(WORDS - 1)) n_state = t_ST_IDLE;
            t_ST_IDLE:  if (finish) n_state = t_ST_MOD;
            t_ST_MOD:   if (mrsp.done) n_state = t_ST_READ;
            t_ST_READ:  n_state = t_ST_WAIT;
            t_ST_WAIT:  n_state = (r_act == ACT_ADD) ? t_ST_WRITE
                                 : ((r_k == 3'd7) ? t_ST_IDLE : t_ST_MOD);
            t_ST_WRITE: n_state = (r_k == 3'd7) ? t_ST_IDLE : t_ST_MOD;
            default:    n_state = t_ST_IDLE;
        endcase
    end

    // Outputs and memory control.
    always_comb begin
        busy     = (r_state != t_ST_IDLE);
        mem_we   = 1'b0;
        mem_addr = AW'(r_pos >> 5);
        mem_wd   = r_rd | (32'd1 << r_pos[4:0]);
        n_clr    = r_clr;
        n_k      = r_k;
        n_all    = r_all;
        unique case (r_state)
            t_ST_CLEAR: begin
                mem_we = 1'b1; mem_addr = r_clr; mem_wd = '0; n_clr = r_clr + AW'(1);
            end
            t_ST_IDLE: begin
                n_k = '0; n_all = 1'b1;
            end
            t_ST_WAIT: begin
                if (r_act == ACT_TEST) begin
                    n_all = r_all & r_rd[r_pos[4:0]];
                    n_k = r_k + 3'd1;
                end
            end
            t_ST_WRITE: begin
                mem_we = 1'b1; n_k = r_k + 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        r_rd <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_CLEAR;
            r_clr <= '0; r_k <= '0; r_all <= 1'b1;
            r_valid <= 1'b0; r_valid_mod <= 1'b0;
            r_rs <= '0; r_rsm <= RS_MUL_INIT; r_js <= JS_INIT; r_pjw <= '0;
            r_elf <= '0; r_bkdr <= '0; r_djb <= DJB_INIT; r_dek <= '0;
            r_ap <= AP_INIT; r_cnt <= '0;
            r_pos <= '0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_k <= n_k; r_all <= n_all;
            r_valid <= (r_state == t_ST_WAIT) && (r_act == ACT_TEST) && (r_k == 3'd7);
            r_valid_mod <= (r_state == t_ST_MOD) && !mrsp.done;
            if (finish) begin
                r_rs <= '0; r_rsm <= RS_MUL_INIT; r_js <= JS_INIT; r_pjw <= '0;
                r_elf <= '0; r_bkdr <= '0; r_djb <= DJB_INIT; r_dek <= '0;
                r_ap <= AP_INIT; r_cnt <= '0;
            end else begin
                r_rs <= n_rs; r_rsm <= n_rsm; r_js <= n_js; r_pjw <= n_pjw;
                r_elf <= n_elf; r_bkdr <= n_bkdr; r_djb <= n_djb; r_dek <= n_dek;
                r_ap <= n_ap; r_cnt <= n_cnt;
            end
            if (mrsp.done) r_pos <= mrsp.rem;
            else if (n_state == t_ST_MOD && r_state != t_ST_MOD) r_pos <= '0;
        end
        if (finish) begin
            r_act <= i_action;
            r_h[0] <= n_rs; r_h[1] <= n_js; r_h[2] <= n_pjw; r_h[3] <= n_elf;
            r_h[4] <= n_bkdr; r_h[5] <= n_djb;
            r_h[6] <= n_dek ^ ((dek_len << dek_rot) | (dek_len >> (6'd32 - {1'b0, dek_rot})));
            r_h[7] <= n_ap;
        end
        r_hit <= n_all;
    end

    assign o_valid      = r_valid;
    assign o_member_hit = r_hit;
endmodule

FILE: hw/rtl/bfh_checker.sv
// Port-level checker for the bloom filter, bound to the top level.
`include "bloom_filter_eight_string_hashes_unit_defines.svh"
module bfh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_end_of_string,
    input logic o_valid
);
    `BF_ASSERT_NEXT(a_byte_no_busy, i_clk, i_rst_n, start && !busy && !i_end_of_string, !busy, "byte beat raised busy")
    `BF_ASSERT_NEXT(a_end_busy, i_clk, i_rst_n, start && !busy && i_end_of_string, busy, "ending beat did not raise busy")
    `BF_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result held longer than one cycle")
    `BF_ASSERT_IMPL(a_valid_after_busy, i_clk, i_rst_n, o_valid, !busy, "result while still busy")
endmodule

bind bloom_filter_eight_string_hashes_unit bfh_checker u_bfh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_end_of_string(i_end_of_string),
    .o_valid        (o_valid)
);

FILE: dv/bloom_filter_eight_string_hashes_unit_tb.sv
// Testbench for the eight-hash bloom filter unit: random strings, add/test checking.
module bloom_filter_eight_string_hashes_unit_tb;
    import bfh_pkg::*;

    localparam int unsigned FSIZE = FILTER_SIZE_DEF;
    localparam int ITEM_GOAL = 1650;

    typedef logic [7:0] t_byte_str[$];

    class bloom_scoreboard;
        logic [31:0] rs, rs_mul, js, pjw, elf, bkdr, djb, dek, ap, len;
        bit          filter_map[];
        bit          hit_queue[$];
        int          errors;
        int          adds, tests, hits;

        function new();
            filter_map = new[FSIZE];
            errors = 0;
            adds = 0;
            tests = 0;
            hits = 0;
            restart_hashes();
        endfunction

        function void restart_hashes();
            rs = 0;
            rs_mul = RS_MUL_INIT;
            js = JS_INIT;
            pjw = 0;
            elf = 0;
            bkdr = 0;
            djb = DJB_INIT;
            dek = 0;
            ap = AP_INIT;
            len = 0;
        endfunction

        function logic [31:0] rot_left(logic [31:0] v, logic [4:0] r);
            return (r == 0) ? v : ((v << r) | (v >> (32 - r)));
        endfunction

        function void fold_byte(logic [7:0] b);
            logic [31:0] c, top;
            c = {{24{b[7]}}, b};
            rs = rs * rs_mul + c;
            rs_mul = rs_mul * RS_MUL_STEP;
            js = js ^ ((js << 5) + c + (js >> 2));
            pjw = (pjw << 4) + c;
            top = pjw & TOP_MASK;
            if (top != 0) pjw = (pjw ^ (top >> 24)) & 32'h0FFFFFFF;
            elf = (elf << 4) + c;
            top = elf & TOP_MASK;
            if (top != 0) elf = elf ^ (top >> 24);
            elf = elf & ~top;
            bkdr = bkdr * BKDR_SEED + c;
            djb = djb * 32'd33 + c;
            dek = rot_left(dek, 5) ^ c;
            if (len[0] == 1'b0)
                ap = ap ^ (ap << 7) ^ (c * (ap >> 3));
            else
                ap = ap ^ ~((ap << 11) + (c ^ (ap >> 5)));
            len = len + 1;
        endfunction

        // Note one accepted beat; queue a hit expectation for test endings.
        function void note_beat(logic act, logic [7:0] b, logic eos, logic nc);
            logic [31:0] h[8];
            logic [31:0] len5;
            bit all_set;
            if (!nc) fold_byte(b);
            if (!eos) return;
            len5 = len * 32'd5;
            h[0] = rs; h[1] = js; h[2] = pjw; h[3] = elf;
            h[4] = bkdr; h[5] = djb; h[6] = dek ^ rot_left(len, len5[4:0]); h[7] = ap;
            all_set = 1;
            for (int k = 0; k < 8; k++) begin
                if (act == ACT_ADD) filter_map[h[k] % FSIZE] = 1;
                else if (!filter_map[h[k] % FSIZE]) all_set = 0;
            end
            restart_hashes();
            if (act == ACT_TEST) begin
                hit_queue.push_back(all_set);
                tests++;
                if (all_set) hits++;
            end else begin
                adds++;
            end
        endfunction

        function void check_hit(logic got);
            bit want;
            if (hit_queue.size() == 0) begin
                $error("unexpected result beat: member_hit=%0b", got);
                errors++;
                return;
            end
            want = hit_queue.pop_front();
            if (got !== want) begin
                $error("member_hit: expected %0b, got %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       start = 0;
    logic       busy;
    logic       i_action = 0;
    logic [7:0] i_char_byte = 0;
    logic       i_end_of_string = 0;
    logic       i_no_char = 0;
    logic       o_valid;
    logic       o_member_hit;

    bloom_scoreboard sb = new();
    t_byte_str added_strs[$];
    int items_sent = 0;

    bloom_filter_eight_string_hashes_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_char_byte(i_char_byte),
        .i_end_of_string(i_end_of_string), .i_no_char(i_no_char),
        .o_valid(o_valid), .o_member_hit(o_member_hit)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_hit(o_member_hit);
    end

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 65) return;
        n = (n < 95) ? $urandom_range(1, 3) : $urandom_range(20, 300);
        start <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drive one beat and hold until the block takes it.
    task automatic send_beat(logic act, logic [7:0] b, logic eos, logic nc);
        idle_gap();
        start <= 1;
        i_action <= act;
        i_char_byte <= b;
        i_end_of_string <= eos;
        i_no_char <= nc;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_beat(act, b, eos, nc);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send a string; end on a no-byte beat or on its last byte.
    task automatic send_string(logic act, t_byte_str s, bit end_blank);
        int n;
        n = s.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0, 1);
            if (i == n - 1 && !end_blank) send_beat(act, s[i], 1, 0);
            else send_beat(1'($urandom_range(0, 1)), s[i], 0, 0);
        end
        if (end_blank || n == 0) send_beat(act, 8'($urandom_range(0, 255)), 1, 1);
        if (act == ACT_ADD) added_strs.push_back(s);
    endtask

    function automatic t_byte_str random_str();
        t_byte_str s;
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (int i = 0; i < n; i++) s.push_back(pick_byte());
        return s;
    endfunction

    initial begin
        t_byte_str s;
        int timeout;
        bit paused;
        paused = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty string, extreme bytes, zero bytes, miss before add.
        s = {};
        send_string(ACT_TEST, s, 1);
        send_string(ACT_ADD, s, 1);
        send_string(ACT_TEST, s, 1);
        s = {8'h00, 8'hFF, 8'h80, 8'h7F};
        send_string(ACT_TEST, s, 0);
        send_string(ACT_ADD, s, 0);
        send_string(ACT_TEST, s, 1);
        s = {8'h00};
        send_string(ACT_ADD, s, 0);
        send_string(ACT_TEST, s, 0);
        s = {8'h55, 8'hAA, 8'h01};
        send_string(ACT_TEST, s, 0);
        send_beat(ACT_TEST, 8'h33, 0, 1);

        while (items_sent < ITEM_GOAL) begin
            // Hold the sender once until every pending result has arrived.
            if (!paused && items_sent > ITEM_GOAL / 2) begin
                paused = 1;
                start <= 0;
                while (sb.hit_queue.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: send_string(ACT_ADD, random_str(), 1'($urandom_range(0, 1)));
                3, 4, 5: begin
                    if (added_strs.size() > 0)
                        send_string(ACT_TEST,
                                    added_strs[$urandom_range(0, added_strs.size() - 1)],
                                    1'($urandom_range(0, 1)));
                    else
                        send_string(ACT_TEST, random_str(), 0);
                end
                default: send_string(ACT_TEST, random_str(), 1'($urandom_range(0, 1)));
            endcase
        end
        start <= 0;

        timeout = 0;
        while (sb.hit_queue.size() != 0 && timeout < 10000) begin
            @(posedge i_clk);
            timeout++;
        end
        repeat (400) @(posedge i_clk);
        if (sb.hit_queue.size() != 0) begin
            $error("%0d member results never arrived", sb.hit_queue.size());
            sb.errors++;
        end

        $display("covered %0d beats: %0d adds, %0d tests (%0d expected hits)",
                 items_sent, sb.adds, sb.tests, sb.hits);
        if (sb.errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #60000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
